[hw/rtl/gas_pkg.sv]
// ============================================================================
// gas_pkg
// Shared types, constants and direction tables of the grid path search block.
// ============================================================================
package gas_pkg;

    localparam int GRID_SIDE_DEF = 8;

    localparam int COORD_W = 3;
    localparam int CELL_W  = 2 * COORD_W;
    localparam int GOAL_W  = 8;
    localparam int STEP_W  = 16;
    localparam int COST_W  = 32;
    localparam int DIR_W   = 3;
    localparam int H_W     = 17;
    localparam int TOT_W   = COST_W + 8 + 1;

    localparam logic [GOAL_W-1:0] GOAL_X_RST   = 8'd100;
    localparam logic [GOAL_W-1:0] GOAL_Y_RST   = 8'd100;
    localparam logic [STEP_W-1:0] STRAIGHT_RST = 16'd10;
    localparam logic [STEP_W-1:0] DIAGONAL_RST = 16'd1400;
    localparam logic [STEP_W-1:0] WALL_RST     = 16'd2500;

    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    typedef enum logic [2:0] {
        REG_GOAL_X   = 3'd0,
        REG_GOAL_Y   = 3'd1,
        REG_STRAIGHT = 3'd2,
        REG_DIAGONAL = 3'd3,
        REG_WALL     = 3'd4
    } reg_idx_t;

    typedef enum logic [0:0] {
        MODE_LOAD   = 1'b0,
        MODE_SEARCH = 1'b1
    } mode_t;

    typedef struct packed {
        logic [GOAL_W-1:0] goal_x;
        logic [GOAL_W-1:0] goal_y;
        logic [STEP_W-1:0] straight_cost;
        logic [STEP_W-1:0] diagonal_step_cost;
        logic [STEP_W-1:0] wall_penalty;
    } cfg_t;

    typedef struct packed {
        logic               start;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } heur_req_t;

    typedef struct packed {
        logic           done;
        logic [H_W-1:0] h;
    } heur_rsp_t;

    typedef enum logic [1:0] {
        HS_IDLE,
        HS_SQX,
        HS_SQY,
        HS_ROOT
    } heur_state_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_HQ_START,
        ST_HQ_WAIT,
        ST_SEL_START,
        ST_SEL_RD,
        ST_SEL_E,
        ST_SEL_T,
        ST_SEL_C,
        ST_REM_RD,
        ST_REM_WR,
        ST_EXP_COST,
        ST_EXP_LAT,
        ST_EXP_D,
        ST_EXP_OCC,
        ST_EXP_W,
        ST_EXP_WA,
        ST_EXP_INS,
        ST_TR_START,
        ST_TR_CHK,
        ST_TR_D,
        ST_EM_RD,
        ST_EM_LD,
        ST_EM_WAIT,
        ST_NOPATH
    } eng_state_t;

    // Column step of direction code d, as a 5-bit two's complement value.
    function automatic logic [4:0] dir_dx(input logic [DIR_W-1:0] d);
        logic [4:0] r;
        unique case (d)
            3'd0, 3'd1, 3'd7: r = 5'b00001;
            3'd3, 3'd4, 3'd5: r = 5'b11111;
            default:          r = 5'b00000;
        endcase
        return r;
    endfunction

    // Row step of direction code d.
    function automatic logic [4:0] dir_dy(input logic [DIR_W-1:0] d);
        logic [4:0] r;
        unique case (d)
            3'd1, 3'd2, 3'd3: r = 5'b00001;
            3'd5, 3'd6, 3'd7: r = 5'b11111;
            default:          r = 5'b00000;
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/grid_astar_path_search.sv]
// ============================================================================
// grid_astar_path_search
// 8-connected A* path search over a square occupancy grid, with register port.
// ============================================================================
//  channel   direction  word contents
//  s_axis    in         tuser: mode; tdata: cell_x, cell_y, blocked
//  m_axis    out        tuser: status; tdata: path_x, path_y; tlast: last
//  apb       in/out     goal_x, goal_y, straight_cost, diagonal_step_cost,
//                       wall_penalty at byte addresses 0, 4, 8, 12, 16
//
// A load word leaves the block in its idle state, ready again in the next cycle.
// A search word first fills the heuristic RAM cell by cell from the square
// root unit, then runs selection passes over the open list, moves up the
// entries behind each removed one and prices each new neighbor.
// Path points leave one by one and wait out any output stall; s_tready stays
// low until the last word of the run is taken. Reset clears occupancy through
// valid bits, so no clearing pass is needed.
module grid_astar_path_search #(
    parameter int GRID_SIDE = gas_pkg::GRID_SIDE_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // cell_x[2:0], cell_y[5:3], blocked[6]
    input  logic                         s_tuser,   // mode[0]
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [7:0]                   m_tdata,   // path_x[2:0], path_y[5:3]
    output logic                         m_tuser,   // status[0]
    output logic                         m_tlast,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gas_pkg::APB_AW-1:0]   paddr,
    input  logic [gas_pkg::APB_DW-1:0]   pwdata,
    output logic [gas_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    import gas_pkg::*;

    cfg_t               cfg_reg;
    logic [2:0]         idx;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;

    assign idx    = paddr[4:2];
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.goal_x             <= GOAL_X_RST;
            cfg_reg.goal_y             <= GOAL_Y_RST;
            cfg_reg.straight_cost      <= STRAIGHT_RST;
            cfg_reg.diagonal_step_cost <= DIAGONAL_RST;
            cfg_reg.wall_penalty       <= WALL_RST;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (idx)
                REG_GOAL_X:   cfg_reg.goal_x             <= pwdata[7:0];
                REG_GOAL_Y:   cfg_reg.goal_y             <= pwdata[7:0];
                REG_STRAIGHT: cfg_reg.straight_cost      <= pwdata[15:0];
                REG_DIAGONAL: cfg_reg.diagonal_step_cost <= pwdata[15:0];
                REG_WALL:     cfg_reg.wall_penalty       <= pwdata[15:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_GOAL_X:   prdata = APB_DW'(cfg_reg.goal_x);
            REG_GOAL_Y:   prdata = APB_DW'(cfg_reg.goal_y);
            REG_STRAIGHT: prdata = APB_DW'(cfg_reg.straight_cost);
            REG_DIAGONAL: prdata = APB_DW'(cfg_reg.diagonal_step_cost);
            REG_WALL:     prdata = APB_DW'(cfg_reg.wall_penalty);
            default:      prdata = '0;
        endcase
    end

    gas_engine #(.GRID_SIDE(GRID_SIDE)) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_mode    (s_tuser),
        .in_x       (s_tdata[2:0]),
        .in_y       (s_tdata[5:3]),
        .in_blocked (s_tdata[6]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_x      (px),
        .out_y      (py),
        .out_status (m_tuser),
        .out_last   (m_tlast)
    );

    assign m_tdata = {2'b00, py, px};

`ifndef SYNTHESIS
    // The engine never takes a word while a result is pending.
    assert property (@(posedge clk) disable iff (!rst_n) m_tvalid |-> !s_tready)
        else $error("input accepted while a result is pending");

    // A search word keeps the block busy for at least the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser) |=> !s_tready)
        else $error("ready right after a search word");

    // A no-path status is always the single, final word at the origin.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata == 8'd0)))
        else $error("malformed no-path word");
`endif

endmodule

[hw/rtl/gas_ram.sv]
// ============================================================================
// gas_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module gas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/gas_heur.sv]
// ============================================================================
// gas_heur
// Q8 Euclidean distance unit: squares the offsets with one multiplier and
// takes an exact integer square root, shifting in two radicand bits per cycle.
// ============================================================================
module gas_heur (
    input  logic                     clk,
    input  logic                     rst_n,
    input  gas_pkg::heur_req_t       req,
    input  logic [gas_pkg::GOAL_W-1:0] goal_x,
    input  logic [gas_pkg::GOAL_W-1:0] goal_y,
    output gas_pkg::heur_rsp_t       rsp
);
    import gas_pkg::*;

    localparam int OP_W  = 34;
    localparam int REM_W = 21;
    localparam int D2_W  = 17;

    heur_state_t      hs_reg, hs_next;
    logic [7:0]       ax_reg, ax_next;
    logic [7:0]       ay_reg, ay_next;
    logic [D2_W-1:0]  d2_reg, d2_next;
    logic [OP_W-1:0]  op_reg, op_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [H_W-1:0]   root_reg, root_next;
    logic [4:0]       it_reg, it_next;
    logic             done_reg, done_next;

    logic [7:0]       mul_in;
    logic [15:0]      sq;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic [7:0]       gx_x;
    logic [7:0]       gy_y;

    assign gx_x   = {5'd0, req.x};
    assign gy_y   = {5'd0, req.y};
    assign mul_in = (hs_reg == HS_SQX) ? ax_reg : ay_reg;
    assign sq     = {8'd0, mul_in} * {8'd0, mul_in};
    assign rem_sh = {rem_reg[REM_W-3:0], op_reg[OP_W-1:OP_W-2]};
    assign trial  = {2'b00, root_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hs_reg   <= HS_IDLE;
            done_reg <= 1'b0;
            it_reg   <= '0;
        end
        else
        begin
            hs_reg   <= hs_next;
            done_reg <= done_next;
            it_reg   <= it_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg   <= ax_next;
        ay_reg   <= ay_next;
        d2_reg   <= d2_next;
        op_reg   <= op_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    always_comb
    begin
        hs_next   = hs_reg;
        ax_next   = ax_reg;
        ay_next   = ay_reg;
        d2_next   = d2_reg;
        op_next   = op_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        it_next   = it_reg;
        done_next = 1'b0;
        unique case (hs_reg)
            HS_IDLE:
            begin
                if (req.start)
                begin
                    ax_next = (goal_x >= gx_x) ? (goal_x - gx_x) : (gx_x - goal_x);
                    ay_next = (goal_y >= gy_y) ? (goal_y - gy_y) : (gy_y - goal_y);
                    hs_next = HS_SQX;
                end
            end
            HS_SQX:
            begin
                d2_next = {1'b0, sq};
                hs_next = HS_SQY;
            end
            HS_SQY:
            begin
                op_next   = {1'b0, d2_reg + D2_W'(sq), 16'd0};
                rem_next  = '0;
                root_next = '0;
                it_next   = '0;
                hs_next   = HS_ROOT;
            end
            HS_ROOT:
            begin
                if (rem_sh >= trial)
                begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_reg[H_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[H_W-2:0], 1'b0};
                end
                op_next = {op_reg[OP_W-3:0], 2'b00};
                it_next = it_reg + 5'd1;
                if (it_reg == 5'(H_W - 1))
                begin
                    done_next = 1'b1;
                    hs_next   = HS_IDLE;
                end
            end
            default:
            begin
                hs_next = HS_IDLE;
            end
        endcase
    end

    assign rsp.done = done_reg;
    assign rsp.h    = root_reg;

endmodule

[hw/rtl/gas_engine.sv]
// ============================================================================
// gas_engine
// Search sequencer: occupancy loads, heuristic fill, open list selection,
// expansion, path trace and path output over RAMs with one write and one read port.
// ============================================================================
module gas_engine #(
    parameter int GRID_SIDE = gas_pkg::GRID_SIDE_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  gas_pkg::cfg_t               cfg,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        in_mode,
    input  logic [gas_pkg::COORD_W-1:0] in_x,
    input  logic [gas_pkg::COORD_W-1:0] in_y,
    input  logic                        in_blocked,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [gas_pkg::COORD_W-1:0] out_x,
    output logic [gas_pkg::COORD_W-1:0] out_y,
    output logic                        out_status,
    output logic                        out_last
);
    import gas_pkg::*;

    localparam int NCELL = GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(NCELL);
    localparam int CW    = $clog2(NCELL + 1);

    function automatic logic [AW-1:0] cell_addr(input logic [CELL_W-1:0] c);
        return AW'(int'(c[5:3]) * GRID_SIDE + int'(c[2:0]));
    endfunction

    function automatic logic in_grid(input logic [4:0] v);
        return (!v[4]) && (v < 5'(GRID_SIDE));
    endfunction

    eng_state_t          state_reg, state_next;
    logic [COORD_W-1:0]  cx_reg, cx_next, cy_reg, cy_next;
    logic [H_W-1:0]      best_h_reg, best_h_next;
    logic [CELL_W-1:0]   tgt_reg, tgt_next;
    logic                tgt_vld_reg, tgt_vld_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [CW-1:0]       j_reg, j_next;
    logic [CW-1:0]       sel_reg, sel_next;
    logic [CW-1:0]       k_reg, k_next;
    logic [CELL_W-1:0]   e_reg, e_next;
    logic [TOT_W-1:0]    tot_reg, tot_next;
    logic [H_W-1:0]      he_reg, he_next;
    logic [TOT_W-1:0]    best_tot_reg, best_tot_next;
    logic [H_W-1:0]      best_he_reg, best_he_next;
    logic [CELL_W-1:0]   selc_reg, selc_next;
    logic [COST_W-1:0]   costc_reg, costc_next;
    logic [DIR_W-1:0]    d_reg, d_next;
    logic [CELL_W-1:0]   n_reg, n_next;
    logic [COST_W-1:0]   acc_reg, acc_next;
    logic [1:0]          w_reg, w_next;
    logic [CELL_W-1:0]   t_reg, t_next;
    logic [CW-1:0]       len_reg, len_next;
    logic [CW-1:0]       r_reg, r_next;
    logic                ov_reg, ov_next;
    logic [COORD_W-1:0]  ox_reg, ox_next, oy_reg, oy_next;
    logic                ost_reg, ost_next;
    logic                olast_reg, olast_next;

    logic [NCELL-1:0]    occ_vld_reg;
    logic [NCELL-1:0]    expl_reg;
    logic                occ_vq_reg;

    logic                occ_set, expl_clr, expl_set;
    logic [AW-1:0]       expl_addr;

    logic                occ_we;
    logic [AW-1:0]       occ_waddr, occ_raddr;
    logic [0:0]          occ_wdata, occ_rdata;
    logic                came_we;
    logic [AW-1:0]       came_waddr, came_raddr;
    logic [DIR_W-1:0]    came_wdata, came_rdata;
    logic                cost_we;
    logic [AW-1:0]       cost_waddr, cost_raddr;
    logic [COST_W-1:0]   cost_wdata, cost_rdata;
    logic                hq_we;
    logic [AW-1:0]       hq_waddr, hq_raddr;
    logic [H_W-1:0]      hq_wdata, hq_rdata;
    logic                ol_we;
    logic [AW-1:0]       ol_waddr, ol_raddr;
    logic [CELL_W-1:0]   ol_wdata, ol_rdata;
    logic                pb_we;
    logic [AW-1:0]       pb_waddr, pb_raddr;
    logic [CELL_W-1:0]   pb_wdata, pb_rdata;

    heur_req_t           hreq;
    heur_rsp_t           hrsp;
    logic                occ_eff;
    logic                goal_in_grid;

    assign occ_eff      = occ_rdata[0] & occ_vq_reg;
    assign goal_in_grid = (cfg.goal_x < GOAL_W'(GRID_SIDE)) &&
                          (cfg.goal_y < GOAL_W'(GRID_SIDE));

    gas_heur u_heur (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (hreq),
        .goal_x (cfg.goal_x),
        .goal_y (cfg.goal_y),
        .rsp    (hrsp)
    );

    gas_ram #(.WIDTH(1), .DEPTH(NCELL)) u_occ (
        .clk(clk), .we(occ_we), .waddr(occ_waddr), .wdata(occ_wdata),
        .raddr(occ_raddr), .rdata(occ_rdata)
    );
    gas_ram #(.WIDTH(DIR_W), .DEPTH(NCELL)) u_came (
        .clk(clk), .we(came_we), .waddr(came_waddr), .wdata(came_wdata),
        .raddr(came_raddr), .rdata(came_rdata)
    );
    gas_ram #(.WIDTH(COST_W), .DEPTH(NCELL)) u_cost (
        .clk(clk), .we(cost_we), .waddr(cost_waddr), .wdata(cost_wdata),
        .raddr(cost_raddr), .rdata(cost_rdata)
    );
    gas_ram #(.WIDTH(H_W), .DEPTH(NCELL)) u_hq (
        .clk(clk), .we(hq_we), .waddr(hq_waddr), .wdata(hq_wdata),
        .raddr(hq_raddr), .rdata(hq_rdata)
    );
    gas_ram #(.WIDTH(CELL_W), .DEPTH(NCELL)) u_open (
        .clk(clk), .we(ol_we), .waddr(ol_waddr), .wdata(ol_wdata),
        .raddr(ol_raddr), .rdata(ol_rdata)
    );
    gas_ram #(.WIDTH(CELL_W), .DEPTH(NCELL)) u_path (
        .clk(clk), .we(pb_we), .waddr(pb_waddr), .wdata(pb_wdata),
        .raddr(pb_raddr), .rdata(pb_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            occ_vld_reg <= '0;
            expl_reg    <= '0;
            occ_vq_reg  <= 1'b0;
            ov_reg      <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ov_reg     <= ov_next;
            cnt_reg    <= cnt_next;
            occ_vq_reg <= occ_vld_reg[occ_raddr];
            if (occ_set)
            begin
                occ_vld_reg[occ_waddr] <= 1'b1;
            end
            // Search start marks every cell unexplored except the start cell.
            if (expl_clr)
            begin
                expl_reg    <= '0;
                expl_reg[0] <= 1'b1;
            end
            else if (expl_set)
            begin
                expl_reg[expl_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        best_h_reg   <= best_h_next;
        tgt_reg      <= tgt_next;
        tgt_vld_reg  <= tgt_vld_next;
        j_reg        <= j_next;
        sel_reg      <= sel_next;
        k_reg        <= k_next;
        e_reg        <= e_next;
        tot_reg      <= tot_next;
        he_reg       <= he_next;
        best_tot_reg <= best_tot_next;
        best_he_reg  <= best_he_next;
        selc_reg     <= selc_next;
        costc_reg    <= costc_next;
        d_reg        <= d_next;
        n_reg        <= n_next;
        acc_reg      <= acc_next;
        w_reg        <= w_next;
        t_reg        <= t_next;
        len_reg      <= len_next;
        r_reg        <= r_next;
        ox_reg       <= ox_next;
        oy_reg       <= oy_next;
        ost_reg      <= ost_next;
        olast_reg    <= olast_next;
    end

    always_comb
    begin
        logic [4:0]    nx;
        logic [4:0]    ny;
        logic          take;
        logic [CW-1:0] sel_v;
        logic [DIR_W-1:0] wd;

        state_next    = state_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        best_h_next   = best_h_reg;
        tgt_next      = tgt_reg;
        tgt_vld_next  = tgt_vld_reg;
        cnt_next      = cnt_reg;
        j_next        = j_reg;
        sel_next      = sel_reg;
        k_next        = k_reg;
        e_next        = e_reg;
        tot_next      = tot_reg;
        he_next       = he_reg;
        best_tot_next = best_tot_reg;
        best_he_next  = best_he_reg;
        selc_next     = selc_reg;
        costc_next    = costc_reg;
        d_next        = d_reg;
        n_next        = n_reg;
        acc_next      = acc_reg;
        w_next        = w_reg;
        t_next        = t_reg;
        len_next      = len_reg;
        r_next        = r_reg;
        ov_next       = ov_reg;
        ox_next       = ox_reg;
        oy_next       = oy_reg;
        ost_next      = ost_reg;
        olast_next    = olast_reg;

        in_ready   = 1'b0;
        occ_set    = 1'b0;
        expl_clr   = 1'b0;
        expl_set   = 1'b0;
        expl_addr  = cell_addr(n_reg);
        hreq.start = 1'b0;
        hreq.x     = cx_reg;
        hreq.y     = cy_reg;

        occ_we     = 1'b0;
        occ_waddr  = cell_addr({in_y, in_x});
        occ_wdata  = in_blocked;
        occ_raddr  = cell_addr({cy_reg, cx_reg});
        came_we    = 1'b0;
        came_waddr = cell_addr(n_reg);
        came_wdata = d_reg;
        came_raddr = cell_addr(t_reg);
        cost_we    = 1'b0;
        cost_waddr = cell_addr(n_reg);
        cost_wdata = acc_reg;
        cost_raddr = cell_addr(selc_reg);
        hq_we      = 1'b0;
        hq_waddr   = cell_addr({cy_reg, cx_reg});
        hq_wdata   = hrsp.h;
        hq_raddr   = cell_addr(e_reg);
        ol_we      = 1'b0;
        ol_waddr   = cnt_reg[AW-1:0];
        ol_wdata   = n_reg;
        ol_raddr   = j_reg[AW-1:0];
        pb_we      = 1'b0;
        pb_waddr   = len_reg[AW-1:0];
        pb_wdata   = t_reg;
        pb_raddr   = r_reg[AW-1:0];

        nx    = {2'b00, selc_reg[2:0]} + dir_dx(d_reg);
        ny    = {2'b00, selc_reg[5:3]} + dir_dy(d_reg);
        take  = 1'b0;
        sel_v = sel_reg;
        wd    = {w_reg, 1'b0};

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_mode == MODE_LOAD)
                    begin
                        if ((32'(in_x) < GRID_SIDE) && (32'(in_y) < GRID_SIDE))
                        begin
                            occ_we  = 1'b1;
                            occ_set = 1'b1;
                        end
                    end
                    else
                    begin
                        expl_clr     = 1'b1;
                        cost_we      = 1'b1;
                        cost_waddr   = '0;
                        cost_wdata   = '0;
                        ol_we        = 1'b1;
                        ol_waddr     = '0;
                        ol_wdata     = '0;
                        cx_next      = '0;
                        cy_next      = '0;
                        tgt_vld_next = 1'b0;
                        state_next   = ST_HQ_START;
                    end
                end
            end
            ST_HQ_START:
            begin
                hreq.start = 1'b1;
                state_next = ST_HQ_WAIT;
            end
            ST_HQ_WAIT:
            begin
                if (hrsp.done)
                begin
                    hq_we = 1'b1;
                    // Nearest free cell scan, used when the goal is off the grid.
                    if ((cx_reg == '0) && (cy_reg == '0))
                    begin
                        best_h_next = hrsp.h;
                    end
                    else if (!occ_eff && (hrsp.h < best_h_reg))
                    begin
                        best_h_next  = hrsp.h;
                        tgt_next     = {cy_reg, cx_reg};
                        tgt_vld_next = 1'b1;
                    end
                    state_next = ST_HQ_START;
                    if (cx_reg == COORD_W'(GRID_SIDE - 1))
                    begin
                        cx_next = '0;
                        cy_next = cy_reg + 3'd1;
                        if (cy_reg == COORD_W'(GRID_SIDE - 1))
                        begin
                            if (goal_in_grid)
                            begin
                                tgt_next     = {cfg.goal_y[2:0], cfg.goal_x[2:0]};
                                tgt_vld_next = 1'b1;
                            end
                            cnt_next   = CW'(1);
                            state_next = ST_SEL_START;
                        end
                    end
                    else
                    begin
                        cx_next = cx_reg + 3'd1;
                    end
                end
            end
            ST_SEL_START:
            begin
                j_next = '0;
                if (cnt_reg == '0)
                begin
                    state_next = ST_NOPATH;
                end
                else
                begin
                    state_next = ST_SEL_RD;
                end
            end
            ST_SEL_RD:
            begin
                state_next = ST_SEL_E;
            end
            ST_SEL_E:
            begin
                if (tgt_vld_reg && (ol_rdata == tgt_reg))
                begin
                    t_next     = ol_rdata;
                    state_next = ST_TR_START;
                end
                else
                begin
                    e_next     = ol_rdata;
                    cost_raddr = cell_addr(ol_rdata);
                    hq_raddr   = cell_addr(ol_rdata);
                    state_next = ST_SEL_T;
                end
            end
            ST_SEL_T:
            begin
                tot_next   = {1'b0, cost_rdata, 8'd0} + TOT_W'(hq_rdata);
                he_next    = hq_rdata;
                state_next = ST_SEL_C;
            end
            ST_SEL_C:
            begin
                take = (j_reg == '0) || (tot_reg < best_tot_reg) ||
                       ((tot_reg == best_tot_reg) && (he_reg <= best_he_reg));
                if (take)
                begin
                    sel_v         = j_reg;
                    best_tot_next = tot_reg;
                    best_he_next  = he_reg;
                    selc_next     = e_reg;
                end
                sel_next = sel_v;
                j_next   = j_reg + CW'(1);
                if (j_reg + CW'(1) == cnt_reg)
                begin
                    k_next     = sel_v;
                    state_next = ST_REM_RD;
                end
                else
                begin
                    state_next = ST_SEL_RD;
                end
            end
            ST_REM_RD:
            begin
                // Close the gap left by the chosen entry, keeping list order.
                ol_raddr = AW'(k_reg + CW'(1));
                if (k_reg + CW'(1) < cnt_reg)
                begin
                    state_next = ST_REM_WR;
                end
                else
                begin
                    cnt_next   = cnt_reg - CW'(1);
                    state_next = ST_EXP_COST;
                end
            end
            ST_REM_WR:
            begin
                ol_we      = 1'b1;
                ol_waddr   = k_reg[AW-1:0];
                ol_wdata   = ol_rdata;
                k_next     = k_reg + CW'(1);
                state_next = ST_REM_RD;
            end
            ST_EXP_COST:
            begin
                state_next = ST_EXP_LAT;
            end
            ST_EXP_LAT:
            begin
                costc_next = cost_rdata;
                d_next     = '0;
                state_next = ST_EXP_D;
            end
            ST_EXP_D:
            begin
                if (in_grid(nx) && in_grid(ny))
                begin
                    n_next     = {ny[2:0], nx[2:0]};
                    occ_raddr  = cell_addr({ny[2:0], nx[2:0]});
                    state_next = ST_EXP_OCC;
                end
                else if (d_reg == 3'd7)
                begin
                    state_next = ST_SEL_START;
                end
                else
                begin
                    d_next = d_reg + 3'd1;
                end
            end
            ST_EXP_OCC:
            begin
                if (occ_eff || expl_reg[cell_addr(n_reg)])
                begin
                    if (d_reg == 3'd7)
                    begin
                        state_next = ST_SEL_START;
                    end
                    else
                    begin
                        d_next     = d_reg + 3'd1;
                        state_next = ST_EXP_D;
                    end
                end
                else
                begin
                    acc_next = costc_reg + COST_W'(d_reg[0] ? cfg.diagonal_step_cost
                                                            : cfg.straight_cost);
                    w_next     = '0;
                    state_next = ST_EXP_W;
                end
            end
            ST_EXP_W:
            begin
                nx = {2'b00, n_reg[2:0]} + dir_dx(wd);
                ny = {2'b00, n_reg[5:3]} + dir_dy(wd);
                if (in_grid(nx) && in_grid(ny))
                begin
                    occ_raddr  = cell_addr({ny[2:0], nx[2:0]});
                    state_next = ST_EXP_WA;
                end
                else if (w_reg == 2'd3)
                begin
                    state_next = ST_EXP_INS;
                end
                else
                begin
                    w_next = w_reg + 2'd1;
                end
            end
            ST_EXP_WA:
            begin
                if (occ_eff)
                begin
                    acc_next = acc_reg + COST_W'(cfg.wall_penalty);
                end
                if (w_reg == 2'd3)
                begin
                    state_next = ST_EXP_INS;
                end
                else
                begin
                    w_next     = w_reg + 2'd1;
                    state_next = ST_EXP_W;
                end
            end
            ST_EXP_INS:
            begin
                if (cnt_reg < CW'(NCELL))
                begin
                    ol_we    = 1'b1;
                    cnt_next = cnt_reg + CW'(1);
                end
                came_we  = 1'b1;
                cost_we  = 1'b1;
                expl_set = 1'b1;
                if (d_reg == 3'd7)
                begin
                    state_next = ST_SEL_START;
                end
                else
                begin
                    d_next     = d_reg + 3'd1;
                    state_next = ST_EXP_D;
                end
            end
            ST_TR_START:
            begin
                pb_we      = 1'b1;
                pb_waddr   = '0;
                len_next   = CW'(1);
                state_next = ST_TR_CHK;
            end
            ST_TR_CHK:
            begin
                if ((t_reg == '0) || (len_reg == CW'(NCELL)))
                begin
                    r_next     = len_reg - CW'(1);
                    state_next = ST_EM_RD;
                end
                else
                begin
                    state_next = ST_TR_D;
                end
            end
            ST_TR_D:
            begin
                nx = {2'b00, t_reg[2:0]} - dir_dx(came_rdata);
                ny = {2'b00, t_reg[5:3]} - dir_dy(came_rdata);
                if (in_grid(nx) && in_grid(ny))
                begin
                    t_next     = {ny[2:0], nx[2:0]};
                    pb_we      = 1'b1;
                    pb_wdata   = {ny[2:0], nx[2:0]};
                    len_next   = len_reg + CW'(1);
                    state_next = ST_TR_CHK;
                end
                else
                begin
                    r_next     = len_reg - CW'(1);
                    state_next = ST_EM_RD;
                end
            end
            ST_EM_RD:
            begin
                state_next = ST_EM_LD;
            end
            ST_EM_LD:
            begin
                ov_next    = 1'b1;
                ox_next    = pb_rdata[2:0];
                oy_next    = pb_rdata[5:3];
                ost_next   = 1'b0;
                olast_next = (r_reg == '0);
                state_next = ST_EM_WAIT;
            end
            ST_EM_WAIT:
            begin
                if (out_ready)
                begin
                    ov_next = 1'b0;
                    if (olast_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        r_next     = r_reg - CW'(1);
                        state_next = ST_EM_RD;
                    end
                end
            end
            ST_NOPATH:
            begin
                ov_next    = 1'b1;
                ox_next    = '0;
                oy_next    = '0;
                ost_next   = 1'b1;
                olast_next = 1'b1;
                state_next = ST_EM_WAIT;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid  = ov_reg;
    assign out_x      = ox_reg;
    assign out_y      = oy_reg;
    assign out_status = ost_reg;
    assign out_last   = olast_reg;

endmodule

[verif/grid_astar_path_search_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_astar_path_search_test
// Loads occupancy cells and launches searches on the grid path search block
// under random stalls on both stream sides outside one calm phase, with a new register setting in
// each phase. An in-bench A* predictor checks every path word as it leaves.
// ----------------------------------------------------------------------------
module grid_astar_path_search_test;
    import gas_pkg::*;

    localparam int SIDE     = 8;
    localparam int NCELLS   = SIDE * SIDE;
    localparam int NO_DIR   = 8;
    localparam int WD_LIMIT = 200000;

    typedef struct {
        mode_t    mode;
        bit [2:0] x;
        bit [2:0] y;
        bit       blocked;
    } cell_word_t;

    typedef struct {
        bit [2:0] x;
        bit [2:0] y;
        bit       status;
        bit       last;
    } path_word_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata = '0;
    logic                s_tuser = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [7:0]          m_tdata;
    logic                m_tuser;
    logic                m_tlast;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [APB_AW-1:0]   paddr = '0;
    logic [APB_DW-1:0]   pwdata = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    cell_word_t pending_cells[$];
    path_word_t path_q[$];
    cell_word_t cur_cell;

    // Predictor state.
    bit        occ[NCELLS];
    bit [7:0]  goal_x_m = GOAL_X_RST;
    bit [7:0]  goal_y_m = GOAL_Y_RST;
    bit [15:0] straight_m = STRAIGHT_RST;
    bit [15:0] diagonal_m = DIAGONAL_RST;
    bit [15:0] wall_m = WALL_RST;

    bit calm = 1'b0;
    bit hold = 1'b0;
    int mismatches = 0;
    int quiet_cycles = 0;

    grid_astar_path_search u_dut (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int step_dx(int d);
        if (d == 0 || d == 1 || d == 7) return 1;
        if (d >= 3 && d <= 5) return -1;
        return 0;
    endfunction

    function automatic int step_dy(int d);
        if (d >= 1 && d <= 3) return 1;
        if (d >= 5) return -1;
        return 0;
    endfunction

    function automatic longint isqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint heur_q8(int x, int y);
        longint dx, dy;
        dx = longint'(x) - longint'(goal_x_m);
        dy = longint'(y) - longint'(goal_y_m);
        return isqrt(longint'(dx * dx + dy * dy) << 16);
    endfunction

    function automatic bit [31:0] wall_sum(int x, int y);
        bit [31:0] s;
        int nx, ny;
        s = 0;
        for (int d = 0; d < 8; d += 2)
        begin
            nx = x + step_dx(d);
            ny = y + step_dy(d);
            if (nx >= 0 && nx < SIDE && ny >= 0 && ny < SIDE && occ[ny * SIDE + nx])
                s += wall_m;
        end
        return s;
    endfunction

    // Runs the search on the current grid and queues the path words it yields.
    task automatic predict_path();
        longint    hq[NCELLS];
        int        from_dir[NCELLS];
        bit [31:0] g[NCELLS];
        int        open_q[$];
        int        trail[$];
        int        tx, ty, target, sel, c, e, nx, ny, n, px, py;
        longint    best_tot, best_h, tot, hbest;
        path_word_t w;
        tx = goal_x_m;
        ty = goal_y_m;
        target = -1;
        for (int i = 0; i < NCELLS; i++)
        begin
            from_dir[i] = NO_DIR;
            g[i] = 0;
            hq[i] = heur_q8(i % SIDE, i / SIDE);
        end
        from_dir[0] = 0;
        if (goal_x_m >= SIDE || goal_y_m >= SIDE)
        begin
            hbest = hq[0];
            for (int i = 1; i < NCELLS; i++)
                if (!occ[i] && hq[i] < hbest)
                begin
                    hbest = hq[i];
                    tx = i % SIDE;
                    ty = i / SIDE;
                end
        end
        open_q.insert(open_q.size(), 0);
        while (target < 0)
        begin
            if (open_q.size() == 0)
            begin
                w = '{x: 0, y: 0, status: 1'b1, last: 1'b1};
                path_q.insert(path_q.size(), w);
                return;
            end
            sel = 0;
            best_tot = 0;
            best_h = 0;
            for (int j = 0; j < open_q.size(); j++)
            begin
                e = open_q[j];
                if (e % SIDE == tx && e / SIDE == ty)
                begin
                    target = e;
                    break;
                end
                tot = (longint'(g[e]) << 8) + hq[e];
                if (j == 0 || tot < best_tot || (tot == best_tot && hq[e] <= best_h))
                begin
                    sel = j;
                    best_tot = tot;
                    best_h = hq[e];
                end
            end
            if (target >= 0) break;
            c = open_q[sel];
            open_q.delete(sel);
            for (int d = 0; d < 8; d++)
            begin
                nx = c % SIDE + step_dx(d);
                ny = c / SIDE + step_dy(d);
                if (nx < 0 || nx >= SIDE || ny < 0 || ny >= SIDE) continue;
                n = ny * SIDE + nx;
                if (occ[n] || from_dir[n] != NO_DIR) continue;
                if (open_q.size() < NCELLS) open_q.insert(open_q.size(), n);
                from_dir[n] = d;
                g[n] = g[c] + ((d % 2) ? diagonal_m : straight_m) + wall_sum(nx, ny);
            end
        end
        trail.push_front(target);
        while (target != 0 && trail.size() < NCELLS)
        begin
            px = target % SIDE - step_dx(from_dir[target] & 7);
            py = target / SIDE - step_dy(from_dir[target] & 7);
            if (px < 0 || px >= SIDE || py < 0 || py >= SIDE) break;
            target = py * SIDE + px;
            trail.push_front(target);
        end
        foreach (trail[k])
        begin
            w = '{x: trail[k] % SIDE, y: trail[k] / SIDE, status: 1'b0,
                  last: (k == trail.size() - 1)};
            path_q.insert(path_q.size(), w);
        end
    endtask

    // Sender of cell and search words.
    always @(posedge clk)
    begin
        bit took;
        took = s_tvalid && s_tready;
        if (took)
        begin
            if (cur_cell.mode == MODE_LOAD)
                occ[cur_cell.y * SIDE + cur_cell.x] = cur_cell.blocked;
            else
                predict_path();
        end
        if (!s_tvalid || took)
        begin
            if (pending_cells.size() > 0 && !hold && (calm || $urandom_range(0, 99) >= 10))
            begin
                cur_cell = pending_cells.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= cur_cell.mode;
                s_tdata <= {1'b0, cur_cell.blocked, cur_cell.y, cur_cell.x};
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver of path words.
    always @(posedge clk)
    begin
        path_word_t want;
        if (m_tvalid && m_tready)
        begin
            if (path_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word x=%0d y=%0d status=%0d last=%0d",
                             m_tdata[2:0], m_tdata[5:3], m_tuser, m_tlast);
            end
            else
            begin
                want = path_q.pop_front();
                if (m_tdata[2:0] !== want.x || m_tdata[5:3] !== want.y ||
                    m_tuser !== want.status || m_tlast !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected x=%0d y=%0d status=%0d last=%0d,",
                                  " got x=%0d y=%0d status=%0d last=%0d"},
                                 want.x, want.y, want.status, want.last,
                                 m_tdata[2:0], m_tdata[5:3], m_tuser, m_tlast);
                end
            end
        end
        m_tready <= calm || $urandom_range(0, 99) >= 10;
    end

    // Watchdog on stretches with no accepted word on either side.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic write_reg(reg_idx_t r, bit [31:0] v);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_AW'(r) << 2;
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (r)
            REG_GOAL_X:   goal_x_m = v[7:0];
            REG_GOAL_Y:   goal_y_m = v[7:0];
            REG_STRAIGHT: straight_m = v[15:0];
            REG_DIAGONAL: diagonal_m = v[15:0];
            REG_WALL:     wall_m = v[15:0];
            default:      ;
        endcase
    endtask

    task automatic set_costs(bit [31:0] gx, bit [31:0] gy, bit [31:0] st,
                             bit [31:0] dg, bit [31:0] wl);
        write_reg(REG_GOAL_X, gx);
        write_reg(REG_GOAL_Y, gy);
        write_reg(REG_STRAIGHT, st);
        write_reg(REG_DIAGONAL, dg);
        write_reg(REG_WALL, wl);
    endtask

    task automatic put_cell(bit srch, int x, int y, bit b);
        cell_word_t c;
        c.mode = srch ? MODE_SEARCH : MODE_LOAD;
        c.x = 3'(x);
        c.y = 3'(y);
        c.blocked = b;
        pending_cells.insert(pending_cells.size(), c);
    endtask

    task automatic drain();
        do @(posedge clk);
        while (pending_cells.size() != 0 || s_tvalid || path_q.size() != 0);
        repeat (10) @(posedge clk);
    endtask

    initial
    begin
        int density;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset goal lies off the grid, so the nearest free cell is the target.
        put_cell(1, 0, 0, 0);
        put_cell(0, 7, 7, 1);
        put_cell(0, 0, 7, 1);
        put_cell(0, 7, 0, 0);
        put_cell(1, 5, 2, 1);
        drain();

        // Goal at the start cell.
        set_costs(0, 0, 0, 0, 0);
        put_cell(1, 0, 0, 0);
        drain();

        // Blocked goal, then a start cell walled in.
        set_costs(3, 3, 65535, 65535, 65535);
        put_cell(0, 3, 3, 1);
        put_cell(1, 0, 0, 0);
        put_cell(0, 3, 3, 0);
        put_cell(0, 1, 0, 1);
        put_cell(0, 0, 1, 1);
        put_cell(0, 1, 1, 1);
        put_cell(1, 7, 7, 0);
        put_cell(0, 1, 0, 0);
        put_cell(0, 0, 1, 0);
        put_cell(0, 1, 1, 0);
        put_cell(0, 7, 7, 0);
        put_cell(0, 0, 7, 0);
        put_cell(1, 0, 0, 0);
        drain();

        for (int ph = 0; ph < 9; ph++)
        begin
            case (ph)
                0: set_costs(7, 7, 10, 14, 0);
                1: set_costs(255, 255, 0, 65535, 2500);
                2: set_costs(0, 255, 65535, 0, 65535);
                3: set_costs(8, 2, 10, 1400, 2500);
                default: set_costs($urandom_range(0, 9), $urandom_range(0, 9),
                                   $urandom_range(0, 65535), $urandom_range(0, 65535),
                                   $urandom_range(0, 65535));
            endcase
            calm = (ph == 4);
            density = $urandom_range(5, 40);
            for (int i = 0; i < 55; i++)
            begin
                if ($urandom_range(0, 11) == 0)
                    put_cell(1, $urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 1));
                else
                    put_cell(0, $urandom_range(0, 7), $urandom_range(0, 7),
                             $urandom_range(0, 99) < density);
                // Hold the sender off until the block has emptied its output.
                if (ph == 5 && i == 30)
                begin
                    put_cell(1, 0, 0, 0);
                    do @(posedge clk);
                    while (pending_cells.size() != 0 || s_tvalid);
                    hold = 1'b1;
                    do @(posedge clk);
                    while (path_q.size() != 0);
                    hold = 1'b0;
                end
            end
            put_cell(1, 0, 0, 0);
            drain();
        end

        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/gas_pkg.sv
hw/rtl/gas_ram.sv
hw/rtl/gas_heur.sv
hw/rtl/gas_engine.sv
hw/rtl/grid_astar_path_search.sv
verif/grid_astar_path_search_test.sv
